>>> sv/wsam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsam_pkg: shared types and constants of the wavetable synthesizer
// Command codes, envelope phase codes, register indexes and envelope types.
// ----------------------------------------------------------------------------
package wsam_pkg;

   localparam int DefChannels      = 4;
   localparam int DefTableDepth    = 256;
   localparam int DefPhaseFracBits = 16;

   localparam int StepW  = 24;
   localparam int LevelW = 17;
   localparam int GainW  = 16;
   localparam int CountW = 24;

   localparam logic [LevelW-1:0] LevelOne = 17'd32768;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_NOTE_ON  = 3'd1,
      CMD_NOTE_OFF = 3'd2,
      CMD_SET_VOL  = 3'd3,
      CMD_TBL_WR   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ENV_IDLE    = 3'd0,
      ENV_ATTACK  = 3'd1,
      ENV_HOLD    = 3'd2,
      ENV_DECAY   = 3'd3,
      ENV_SUSTAIN = 3'd4,
      ENV_RELEASE = 3'd5
   } env_phase_type;

   typedef enum logic [2:0] {
      CSR_MAIN_VOLUME   = 3'd0,
      CSR_ATTACK_STEP   = 3'd1,
      CSR_HOLD_TICKS    = 3'd2,
      CSR_DECAY_STEP    = 3'd3,
      CSR_SUSTAIN_GAIN  = 3'd4,
      CSR_SUSTAIN_TICKS = 3'd5,
      CSR_RELEASE_STEP  = 3'd6
   } csr_index_type;

   typedef struct packed {
      env_phase_type     phase;
      logic [LevelW-1:0] level;
      logic [CountW-1:0] count;
   } env_state_type;

   typedef struct packed {
      logic [GainW-1:0]  attack_step;
      logic [CountW-1:0] hold_ticks;
      logic [GainW-1:0]  decay_step;
      logic [GainW-1:0]  sustain_gain;
      logic [CountW-1:0] sustain_ticks;
      logic [GainW-1:0]  release_step;
   } env_cfg_type;

endpackage
`default_nettype wire

>>> sv/wavetable_synth_ahdsr_mixer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavetable_synth_ahdsr_mixer_top: multi-channel wavetable synthesizer
// Wavetable memory and per-channel state memory; each tick reads every channel
// in turn, steps and writes back the active ones, mixes the parts and applies main gain.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// req_      in         command, channel, phase step, gain, table index/value
// rsp_      out        mixed sample, one per tick command
// csr_      in         register index and write data, always ready
//
// On a tick each active channel walks the state memory read, wave memory
// read and envelope write-back in turn before the mix reaches the output
// register. Note on, note off and volume commands read the channel entry and
// write it back; a table write is done when the word is accepted.
// Reset clears the state, the channel valid bits and the main volume and
// loads the envelope defaults; the wavetable keeps whatever it holds.
// A stalled result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module wavetable_synth_ahdsr_mixer_top
   import wsam_pkg::*;
#(
   parameter int CHANNELS        = DefChannels,
   parameter int TABLE_DEPTH     = DefTableDepth,
   parameter int PHASE_FRAC_BITS = DefPhaseFracBits
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire logic [2:0]   req_command,
   input  wire logic [1:0]   req_channel,
   input  wire logic [23:0]  req_phase_step,
   input  wire logic [7:0]   req_chan_gain,
   input  wire logic [7:0]   req_table_index,
   input  wire logic [7:0]   req_table_value,
   output      logic         rsp_valid,
   input  wire logic         rsp_ready,
   output      logic [7:0]   rsp_sample,
   input  wire logic         csr_valid,
   output      logic         csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [23:0]  csr_wdata
);

   localparam int TW = $clog2(TABLE_DEPTH);
   localparam int PW = TW + PHASE_FRAC_BITS;
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CW-1:0] LastChan = CW'(CHANNELS - 1);

   typedef struct packed {
      logic [PW-1:0]    acc;
      logic [StepW-1:0] inc;
      logic [7:0]       vol;
      env_state_type    env;
   } chan_word_type;

   typedef enum logic [2:0] {
      S_IDLE, S_WV, S_MUL, S_ACC, S_CMD, S_OUT
   } state_type;

   // Registers
   logic [7:0]    main_volume_ff;
   env_cfg_type   cfg_ff;
   state_type     state_ff;
   logic [CW-1:0] chan_ff;
   cmd_type       cmd_ff;
   logic [StepW-1:0] step_ff;
   logic [7:0]    gain_arg_ff;
   chan_word_type cur_ff;
   logic [15:0]   x0_ff;
   logic [LevelW-1:0] gain_ff;
   logic          byp_ff;
   logic [7:0]    mix_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_sample_ff;

   // Memories
   logic [7:0]    wave_mem [TABLE_DEPTH];
   logic [7:0]    wave_q;
   chan_word_type cmem [CHANNELS];
   chan_word_type cm_q;
   logic [CHANNELS-1:0] cval_ff;
   logic          cm_qv_ff;

   logic          req_acc;
   logic          ch_ok;
   logic          tbl_ok;
   logic          cm_re;
   logic [CW-1:0] cm_raddr;
   logic          cm_we;
   chan_word_type cm_wdata;
   logic          wv_re;
   logic [TW-1:0] wv_raddr;
   chan_word_type chan_rd;
   logic          active;
   logic          last;
   env_state_type env_next;
   logic [LevelW-1:0] env_gain;
   logic          env_byp;
   logic [7:0]    x_part;
   logic [LevelW+7:0] scaled;
   logic [7:0]    part;
   logic [15:0]   out_prod;
   logic          out_load;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_acc    = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   assign ch_ok   = 32'(req_channel) < CHANNELS;
   assign tbl_ok  = 32'(req_table_index) < TABLE_DEPTH;
   assign chan_rd = cm_qv_ff ? cm_q : '0;
   assign last    = (chan_ff == LastChan);
   assign active  = (chan_rd.inc != '0) &&
                    (chan_rd.env.phase == ENV_ATTACK  || chan_rd.env.phase == ENV_HOLD ||
                     chan_rd.env.phase == ENV_DECAY   || chan_rd.env.phase == ENV_SUSTAIN ||
                     chan_rd.env.phase == ENV_RELEASE);

   wsam_env u_env (
      .env_i  (cur_ff.env),
      .cfg    (cfg_ff),
      .env_o  (env_next),
      .gain   (env_gain),
      .bypass (env_byp)
   );

   assign x_part   = x0_ff[15:8];
   assign scaled   = x_part * gain_ff;
   assign part     = byp_ff ? x_part : scaled[22:15];
   assign out_prod = mix_ff * main_volume_ff;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Memory port control
   always_comb begin
      cm_re    = 1'b0;
      cm_raddr = chan_ff + 1'b1;
      wv_re    = 1'b0;
      wv_raddr = chan_rd.acc[PW-1:PHASE_FRAC_BITS];
      cm_we    = 1'b0;
      cm_wdata = cur_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && req_command == CMD_TICK) begin
               cm_re    = 1'b1;
               cm_raddr = '0;
            end else if (req_acc && ch_ok) begin
               cm_re    = 1'b1;
               cm_raddr = CW'(req_channel);
            end
         end
         S_WV: begin
            wv_re = active;
            cm_re = !active && !last;
         end
         S_MUL: begin
            cm_we          = 1'b1;
            cm_wdata.acc   = cur_ff.acc + PW'(cur_ff.inc);
            cm_wdata.env   = env_next;
         end
         S_ACC: begin
            cm_re = !last;
         end
         S_CMD: begin
            cm_wdata = chan_rd;
            unique case (cmd_ff)
               CMD_NOTE_ON: begin
                  cm_we        = 1'b1;
                  cm_wdata.inc = step_ff;
                  if (step_ff != '0) begin
                     cm_wdata.acc       = '0;
                     cm_wdata.env.phase = ENV_ATTACK;
                     cm_wdata.env.level = '0;
                     cm_wdata.env.count = '0;
                  end else begin
                     cm_wdata.env.phase = ENV_IDLE;
                  end
               end
               CMD_NOTE_OFF: begin
                  cm_we              = 1'b1;
                  cm_wdata.acc       = '0;
                  cm_wdata.inc       = '0;
                  cm_wdata.env.phase = ENV_IDLE;
               end
               CMD_SET_VOL: begin
                  cm_we        = 1'b1;
                  cm_wdata.vol = gain_arg_ff;
               end
               default: begin
                  cm_we = 1'b0;
               end
            endcase
         end
         default: begin
            cm_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_command == CMD_TBL_WR && tbl_ok) begin
         wave_mem[TW'(req_table_index)] <= req_table_value;
      end
      if (wv_re) begin
         wave_q <= wave_mem[wv_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cm_we) begin
         cmem[chan_ff] <= cm_wdata;
      end
      if (cm_re) begin
         cm_q <= cmem[cm_raddr];
      end
   end

   // An entry reads as all zero until its first write after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cval_ff  <= '0;
         cm_qv_ff <= 1'b0;
      end else begin
         if (cm_we) begin
            cval_ff[chan_ff] <= 1'b1;
         end
         if (cm_re) begin
            cm_qv_ff <= cval_ff[cm_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_volume_ff       <= 8'd0;
         cfg_ff.attack_step   <= 16'd328;
         cfg_ff.hold_ticks    <= 24'd0;
         cfg_ff.decay_step    <= 16'd328;
         cfg_ff.sustain_gain  <= 16'd16384;
         cfg_ff.sustain_ticks <= 24'd0;
         cfg_ff.release_step  <= 16'd328;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAIN_VOLUME:   main_volume_ff       <= csr_wdata[7:0];
            CSR_ATTACK_STEP:   cfg_ff.attack_step   <= csr_wdata[15:0];
            CSR_HOLD_TICKS:    cfg_ff.hold_ticks    <= csr_wdata;
            CSR_DECAY_STEP:    cfg_ff.decay_step    <= csr_wdata[15:0];
            CSR_SUSTAIN_GAIN:  cfg_ff.sustain_gain  <= csr_wdata[15:0];
            CSR_SUSTAIN_TICKS: cfg_ff.sustain_ticks <= csr_wdata;
            CSR_RELEASE_STEP:  cfg_ff.release_step  <= csr_wdata[15:0];
            default:           main_volume_ff       <= main_volume_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  cmd_ff      <= cmd_type'(req_command);
                  step_ff     <= req_phase_step;
                  gain_arg_ff <= req_chan_gain;
                  mix_ff      <= '0;
                  if (req_command == CMD_TICK) begin
                     chan_ff  <= '0;
                     state_ff <= S_WV;
                  end else if (ch_ok && (req_command == CMD_NOTE_ON ||
                               req_command == CMD_NOTE_OFF || req_command == CMD_SET_VOL)) begin
                     chan_ff  <= CW'(req_channel);
                     state_ff <= S_CMD;
                  end
               end
            end
            S_WV: begin
               if (active) begin
                  cur_ff   <= chan_rd;
                  state_ff <= S_MUL;
               end else if (last) begin
                  state_ff <= S_OUT;
               end else begin
                  chan_ff <= chan_ff + 1'b1;
               end
            end
            S_MUL: begin
               x0_ff    <= wave_q * cur_ff.vol;
               gain_ff  <= env_gain;
               byp_ff   <= env_byp;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               mix_ff <= mix_ff + part;
               if (last) begin
                  state_ff <= S_OUT;
               end else begin
                  chan_ff  <= chan_ff + 1'b1;
                  state_ff <= S_WV;
               end
            end
            S_CMD: begin
               state_ff <= S_IDLE;
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_sample_ff <= out_prod[15:8];
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A sample is loaded only when a tick finishes its channel walk.
   a_out_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("sample loaded outside the output state");

   // The state memory is written back only after a read of the same entry.
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cm_we |-> (state_ff == S_MUL || state_ff == S_CMD))
      else $error("channel state written outside write-back");

   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC |-> $past(state_ff == S_MUL))
      else $error("mix accumulated without a scaled part");

   a_no_sample_for_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_command != CMD_TICK) |=> !$rose(rsp_valid_ff))
      else $error("sample produced for a non-tick command");

endmodule
`default_nettype wire

>>> sv/wsam_env.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsam_env: one envelope step
// Gives the next envelope state of a channel for one tick, and the gain that
// scales the channel's sample on that tick, or a bypass in the hold phase.
// ----------------------------------------------------------------------------
module wsam_env
   import wsam_pkg::*;
(
   input  env_state_type     env_i,
   input  env_cfg_type       cfg,
   output env_state_type     env_o,
   output logic [LevelW-1:0] gain,
   output logic              bypass
);

   logic [LevelW:0]   rise;
   logic [LevelW:0]   fall_dec;
   logic [LevelW:0]   fall_rel;
   logic [CountW-1:0] count_inc;

   assign rise      = {1'b0, env_i.level} + {2'b00, cfg.attack_step};
   assign fall_dec  = {1'b0, env_i.level} - {2'b00, cfg.decay_step};
   assign fall_rel  = {1'b0, env_i.level} - {2'b00, cfg.release_step};
   assign count_inc = env_i.count + 1'b1;

   always_comb begin
      env_o  = env_i;
      gain   = '0;
      bypass = 1'b0;
      unique case (env_i.phase)
         ENV_ATTACK: begin
            gain        = env_i.level;
            env_o.level = rise[LevelW-1:0];
            if (rise[LevelW-1:0] >= LevelOne) begin
               env_o.phase = ENV_HOLD;
               env_o.count = '0;
            end
         end
         ENV_HOLD: begin
            bypass      = 1'b1;
            env_o.count = count_inc;
            if (count_inc >= cfg.hold_ticks) begin
               env_o.phase = ENV_DECAY;
               env_o.level = LevelOne;
            end
         end
         ENV_DECAY: begin
            gain        = env_i.level;
            // A fall below zero is stored as zero and always reaches sustain.
            env_o.level = fall_dec[LevelW] ? '0 : fall_dec[LevelW-1:0];
            if (fall_dec[LevelW] || fall_dec[LevelW-1:0] <= {1'b0, cfg.sustain_gain}) begin
               env_o.phase = ENV_SUSTAIN;
               env_o.count = '0;
            end
         end
         ENV_SUSTAIN: begin
            gain        = {1'b0, cfg.sustain_gain};
            env_o.count = count_inc;
            if (count_inc >= cfg.sustain_ticks) begin
               env_o.phase = ENV_RELEASE;
               env_o.level = {1'b0, cfg.sustain_gain};
            end
         end
         ENV_RELEASE: begin
            gain        = env_i.level;
            env_o.level = fall_rel[LevelW] ? '0 : fall_rel[LevelW-1:0];
            if (fall_rel[LevelW] || fall_rel[LevelW-1:0] == '0) begin
               env_o.phase = ENV_IDLE;
               env_o.level = '0;
               env_o.count = '0;
            end
         end
         default: begin
            gain = '0;
         end
      endcase
   end

endmodule
`default_nettype wire
